// ===== src/font_glyph_kern_lookup_unit_defines.svh =====
// assertion macros for the glyph and kern lookup unit
`ifndef FONT_GLYPH_KERN_LOOKUP_UNIT_DEFINES_SVH
`define FONT_GLYPH_KERN_LOOKUP_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FGK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define FGK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fgk_pkg.sv =====
// ----------------------------------------------------------------------------
// fgk_pkg
// Shared types and codes for the glyph and kern lookup unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fgk_pkg;

  // request opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_GLYPH = 2'd1;
  localparam logic [1:0] OP_KERN  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_CODE_BYTES   = 3'd0;
  localparam logic [2:0] REG_METRIC_BYTES = 3'd1;
  localparam logic [2:0] REG_OFFSET_BYTES = 3'd2;
  localparam logic [2:0] REG_GLYPH_ENTRIES = 3'd3;
  localparam logic [2:0] REG_KERN_ENTRIES = 3'd4;
  localparam logic [2:0] REG_KERN_BASE    = 3'd5;
  localparam logic [2:0] REG_LINE_GAP     = 3'd6;

  // field selectors for bytes shifted into the datapath
  localparam logic [3:0] FLD_KEY    = 4'd0;
  localparam logic [3:0] FLD_XMIN   = 4'd1;
  localparam logic [3:0] FLD_YMIN   = 4'd2;
  localparam logic [3:0] FLD_XMAX   = 4'd3;
  localparam logic [3:0] FLD_YMAX   = 4'd4;
  localparam logic [3:0] FLD_ADV    = 4'd5;
  localparam logic [3:0] FLD_OFFSET = 4'd6;
  localparam logic [3:0] FLD_KERN   = 4'd7;

  // controller to datapath commands
  typedef struct packed {
    logic       load;       // capture request and set up search bounds
    logic       probe_addr; // compute entry address of the midpoint
    logic       set_rd;     // start byte pointer at entry address
    logic       rd_next;    // advance byte pointer
    logic       shift_en;   // shift read byte into field selected
    logic [3:0] field;
    logic       step;       // update bounds from compare
    logic       finish;     // register result and strobe it
  } fgk_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       is_glyph;
    logic       empty;      // lo > hi
    logic       match;
    logic [1:0] cb;
    logic [1:0] mb;
    logic [1:0] ob;
  } fgk_sts_t;

endpackage

// ===== src/fgk_datapath.sv =====
// ----------------------------------------------------------------------------
// fgk_datapath
// Byte store, search bounds, entry address and field assembly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fgk_datapath #(
  parameter int ADDR_W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic [1:0]          in_opcode,
  input  logic [15:0]         in_store_address,
  input  logic [7:0]          in_store_byte,
  input  logic [15:0]         in_glyph_code,
  input  logic [15:0]         in_right_code,
  input  logic                in_vertical_layout,
  input  logic [1:0]          cfg_code_bytes,
  input  logic [1:0]          cfg_metric_bytes,
  input  logic [1:0]          cfg_offset_field_bytes,
  input  logic [15:0]         cfg_glyph_entries,
  input  logic [15:0]         cfg_kern_entries,
  input  logic [15:0]         cfg_kern_table_base,
  input  logic [15:0]         cfg_line_gap,
  input  fgk_pkg::fgk_cmd_t   cmd,
  output fgk_pkg::fgk_sts_t   sts,
  output logic                out_strobe,
  output logic                out_found,
  output logic signed [15:0]  out_x_min,
  output logic signed [15:0]  out_y_min,
  output logic signed [15:0]  out_x_max,
  output logic signed [15:0]  out_y_max,
  output logic signed [15:0]  out_advance,
  output logic [23:0]         out_bitmap_offset,
  output logic [7:0]          out_kern_amount
);

  // byte store, undefined until written
  logic [7:0] mem [0:(1 << ADDR_W) - 1];
  logic [7:0] rd_data_r;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;

  always_ff @(posedge clk) begin
    if (in_accept && in_opcode == fgk_pkg::OP_WRITE) begin
      mem[in_store_address[ADDR_W-1:0]] <= in_store_byte;
    end
    rd_data_r <= mem[rd_ptr_nxt];
  end

  // request capture and effective sizes
  logic        glyph_r;
  logic        vert_r;
  logic [31:0] key_r;
  logic [1:0]  cb_r, mb_r, ob_r;
  logic [4:0]  esize_r;
  logic [16:0] base_r;

  logic [1:0] cb_eff, mb_eff, ob_eff;
  assign cb_eff = (cfg_code_bytes >= 2'd2) ? 2'd2 : 2'd1;
  assign mb_eff = (cfg_metric_bytes >= 2'd2) ? 2'd2 : 2'd1;
  assign ob_eff = (cfg_offset_field_bytes == 2'd0) ? 2'd1 : cfg_offset_field_bytes;

  // search bounds, signed 18 bit so hi may go to -1
  logic signed [17:0] lo_r, hi_r;
  logic [15:0] mid;
  logic signed [17:0] diff;
  assign diff = hi_r - lo_r;
  assign mid  = 16'(lo_r + (diff >>> 1));

  // entry address
  logic [23:0] ent_addr_r;

  // assembled fields
  logic [31:0] kv_r;
  logic [15:0] xmn_r, ymn_r, xmx_r, ymx_r, adv_r;
  logic [23:0] off_r;
  logic [7:0]  kb_r;
  logic        found_r;

  // key value: kern key packs left code high, right low
  logic [31:0] kv_cmp;
  always_comb begin
    kv_cmp = kv_r;
    if (!glyph_r && cb_r == 2'd1) begin
      kv_cmp = {8'd0, kv_r[15:8], 8'd0, kv_r[7:0]};
    end
  end

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    if (cmd.set_rd) begin
      rd_ptr_nxt = ent_addr_r[ADDR_W-1:0];
    end else if (cmd.rd_next) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    // capture request
    if (cmd.load) begin
      glyph_r <= (in_opcode == fgk_pkg::OP_GLYPH);
      vert_r  <= in_vertical_layout;
      cb_r    <= cb_eff;
      mb_r    <= mb_eff;
      ob_r    <= ob_eff;
      lo_r    <= '0;
      found_r <= 1'b0;
      kv_r    <= '0;
      xmn_r   <= '0; ymn_r <= '0; xmx_r <= '0; ymx_r <= '0; adv_r <= '0;
      off_r   <= '0; kb_r <= '0;
      if (in_opcode == fgk_pkg::OP_GLYPH) begin
        key_r   <= {16'd0, in_glyph_code};
        esize_r <= 5'(cb_eff) + 5'(mb_eff) * 5'd5 + 5'(ob_eff);
        base_r  <= '0;
        hi_r    <= $signed({2'b00, cfg_glyph_entries}) - 18'sd1;
      end else begin
        key_r   <= {in_glyph_code, in_right_code};
        esize_r <= 5'({cb_eff, 1'b1});
        base_r  <= {1'b0, cfg_kern_table_base};
        hi_r    <= $signed({2'b00, cfg_kern_entries}) - 18'sd1;
      end
    end
    // midpoint entry address, 16 by 5 multiply
    if (cmd.probe_addr) begin
      ent_addr_r <= 24'(base_r) + 24'(mid) * 24'(esize_r);
      kv_r       <= '0;
    end
    // byte assembly
    if (cmd.shift_en) begin
      case (cmd.field)
        fgk_pkg::FLD_KEY:    kv_r  <= {kv_r[23:0], rd_data_r};
        fgk_pkg::FLD_XMIN:   xmn_r <= {xmn_r[7:0], rd_data_r};
        fgk_pkg::FLD_YMIN:   ymn_r <= {ymn_r[7:0], rd_data_r};
        fgk_pkg::FLD_XMAX:   xmx_r <= {xmx_r[7:0], rd_data_r};
        fgk_pkg::FLD_YMAX:   ymx_r <= {ymx_r[7:0], rd_data_r};
        fgk_pkg::FLD_ADV:    adv_r <= {adv_r[7:0], rd_data_r};
        fgk_pkg::FLD_OFFSET: off_r <= {off_r[15:0], rd_data_r};
        fgk_pkg::FLD_KERN:   kb_r  <= rd_data_r;
        default: ;
      endcase
    end
    // bound update
    if (cmd.step) begin
      if (kv_cmp == key_r) begin
        found_r <= 1'b1;
      end else if (key_r < kv_cmp) begin
        hi_r <= $signed({2'b00, mid}) - 18'sd1;
      end else begin
        lo_r <= $signed({2'b00, mid}) + 18'sd1;
      end
    end
  end

  assign sts.is_glyph = glyph_r;
  assign sts.empty    = lo_r > hi_r;
  assign sts.match    = (kv_cmp == key_r);
  assign sts.cb       = cb_r;
  assign sts.mb       = mb_r;
  assign sts.ob       = ob_r;

  // sign extension of one-byte metrics
  function automatic logic [15:0] sx(input logic [15:0] v, input logic [1:0] mb);
    sx = (mb == 2'd1) ? {{8{v[7]}}, v[7:0]} : v;
  endfunction

  logic [15:0] xmn_e, ymn_e, xmx_e, ymx_e, adv_e;
  assign xmn_e = sx(xmn_r, mb_r);
  assign ymn_e = sx(ymn_r, mb_r);
  assign xmx_e = sx(xmx_r, mb_r);
  assign ymx_e = sx(ymx_r, mb_r);
  assign adv_e = sx(adv_r, mb_r);

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.finish;
    end
    if (cmd.finish) begin
      out_found         <= found_r;
      out_x_min         <= (glyph_r && found_r) ? xmn_e : '0;
      out_y_min         <= (glyph_r && found_r) ? ymn_e : '0;
      out_x_max         <= (glyph_r && found_r) ? xmx_e : '0;
      out_y_max         <= (glyph_r && found_r) ? ymx_e : '0;
      out_advance       <= !(glyph_r && found_r) ? '0 :
                           vert_r ? ymx_e - ymn_e + 16'd1 + cfg_line_gap : adv_e;
      out_bitmap_offset <= (glyph_r && found_r) ? off_r : '0;
      out_kern_amount   <= (!glyph_r && found_r) ? kb_r : '0;
    end
  end

endmodule

// ===== src/fgk_ctrl.sv =====
// ----------------------------------------------------------------------------
// fgk_ctrl
// Sequencer for probes and field reads of the lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "font_glyph_kern_lookup_unit_defines.svh"

module fgk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_opcode,
  input  fgk_pkg::fgk_sts_t sts,
  output logic              busy,
  output fgk_pkg::fgk_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_PTR   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_STEP  = 3'd5;
  localparam logic [2:0] S_FIELD = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;     // bytes left in current field
  logic [3:0] fld_r, fld_nxt;     // field being read
  logic       key_phase_r, key_phase_nxt;

  // byte count per field
  function automatic logic [2:0] fbytes(input logic [3:0] f, input fgk_pkg::fgk_sts_t s);
    case (f)
      fgk_pkg::FLD_KEY:    fbytes = s.is_glyph ? 3'(s.cb) : 3'({s.cb, 1'b0});
      fgk_pkg::FLD_OFFSET: fbytes = 3'(s.ob);
      fgk_pkg::FLD_KERN:   fbytes = 3'd1;
      default:             fbytes = 3'(s.mb);
    endcase
  endfunction

  logic go;
  assign go   = start && !busy &&
                (in_opcode == fgk_pkg::OP_GLYPH || in_opcode == fgk_pkg::OP_KERN);
  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    fld_nxt   = fld_r;
    key_phase_nxt = key_phase_r;
    cmd = '0;
    cmd.field = fld_r;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = sts.empty ? S_DONE : S_ADDR;
      end
      S_ADDR: begin
        cmd.probe_addr = 1'b1;
        fld_nxt   = fgk_pkg::FLD_KEY;
        cnt_nxt   = fbytes(fgk_pkg::FLD_KEY, sts);
        key_phase_nxt = 1'b1;
        state_nxt = S_PTR;
      end
      S_PTR: begin
        cmd.set_rd = 1'b1;
        state_nxt  = S_READ;
      end
      S_READ: begin
        cmd.shift_en = 1'b1;
        cmd.rd_next  = 1'b1;
        cnt_nxt      = cnt_r - 3'd1;
        if (cnt_r == 3'd1) begin
          state_nxt = key_phase_r ? S_STEP : S_FIELD;
        end
      end
      S_STEP: begin
        key_phase_nxt = 1'b0;
        if (sts.match) begin
          cmd.step = 1'b1;
          fld_nxt  = sts.is_glyph ? fgk_pkg::FLD_XMIN : fgk_pkg::FLD_KERN;
          cnt_nxt  = sts.is_glyph ? 3'(sts.mb) : 3'd1;
          state_nxt = S_READ;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_FIELD: begin
        if (fld_r == fgk_pkg::FLD_OFFSET || fld_r == fgk_pkg::FLD_KERN) begin
          state_nxt = S_DONE;
        end else begin
          fld_nxt   = fld_r + 4'd1;
          cnt_nxt   = fbytes(fld_r + 4'd1, sts);
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fld_r       <= fgk_pkg::FLD_KEY;
      key_phase_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fld_r       <= fld_nxt;
      key_phase_r <= key_phase_nxt;
    end
  end

  `FGK_ASSERT_NEXT(a_done_to_idle, state_r == S_DONE, state_r == S_IDLE, "done not followed by idle")
  `FGK_ASSERT_IMP(a_read_cnt, state_r == S_READ, cnt_r != 3'd0, "read with zero byte count")
  `FGK_ASSERT_NEXT(a_go_busy, go, busy, "accepted lookup left controller idle")

endmodule

// ===== src/font_glyph_kern_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// font_glyph_kern_lookup_unit
// Glyph metrics and kerning lookup by binary search over a byte store.
// ----------------------------------------------------------------------------
// A store write is taken only while busy is low and leaves busy low. A
// lookup holds busy while it probes: each probe, of up to 16 for a full
// table, computes the midpoint entry address, points the read pointer at
// it and reads the key bytes of the entry (code_bytes for a glyph, twice
// that for a kern pair) one byte a cycle from the byte store, then steps
// the search bounds; a miss ends when the bounds are empty. A hit ends
// instead with the rest of the entry read one byte a cycle, field by field,
// before it finishes. The result shows on the out_ ports in the first
// cycle with busy low again, marked by out_valid for a single cycle; the
// receiver cannot stall it and must take it then.
`timescale 1ns / 1ps

module font_glyph_kern_lookup_unit #(
  parameter int STORE_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [15:0]        in_store_address,
  input  logic [7:0]         in_store_byte,
  input  logic [15:0]        in_glyph_code,
  input  logic [15:0]        in_right_code,
  input  logic               in_vertical_layout,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  output logic               out_found,
  output logic signed [15:0] out_x_min,
  output logic signed [15:0] out_y_min,
  output logic signed [15:0] out_x_max,
  output logic signed [15:0] out_y_max,
  output logic signed [15:0] out_advance,
  output logic [23:0]        out_bitmap_offset,
  output logic [7:0]         out_kern_amount
);

  localparam int AW = (STORE_BYTES > 65536) ? 16 : $clog2(STORE_BYTES);

  // configuration registers
  logic [1:0]  code_bytes_r, metric_bytes_r, offset_bytes_r;
  logic [15:0] glyph_entries_r, kern_entries_r, kern_base_r, line_gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_bytes_r    <= 2'd1;
      metric_bytes_r  <= 2'd1;
      offset_bytes_r  <= 2'd2;
      glyph_entries_r <= '0;
      kern_entries_r  <= '0;
      kern_base_r     <= '0;
      line_gap_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fgk_pkg::REG_CODE_BYTES:    code_bytes_r    <= cfg_data[1:0];
        fgk_pkg::REG_METRIC_BYTES:  metric_bytes_r  <= cfg_data[1:0];
        fgk_pkg::REG_OFFSET_BYTES:  offset_bytes_r  <= cfg_data[1:0];
        fgk_pkg::REG_GLYPH_ENTRIES: glyph_entries_r <= cfg_data;
        fgk_pkg::REG_KERN_ENTRIES:  kern_entries_r  <= cfg_data;
        fgk_pkg::REG_KERN_BASE:     kern_base_r     <= cfg_data;
        fgk_pkg::REG_LINE_GAP:      line_gap_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  fgk_pkg::fgk_cmd_t cmd;
  fgk_pkg::fgk_sts_t sts;
  logic accept;
  assign accept = start && !busy;

  fgk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  fgk_datapath #(.ADDR_W(AW)) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_accept              (accept),
    .in_opcode              (in_opcode),
    .in_store_address       (in_store_address),
    .in_store_byte          (in_store_byte),
    .in_glyph_code          (in_glyph_code),
    .in_right_code          (in_right_code),
    .in_vertical_layout     (in_vertical_layout),
    .cfg_code_bytes         (code_bytes_r),
    .cfg_metric_bytes       (metric_bytes_r),
    .cfg_offset_field_bytes (offset_bytes_r),
    .cfg_glyph_entries      (glyph_entries_r),
    .cfg_kern_entries       (kern_entries_r),
    .cfg_kern_table_base    (kern_base_r),
    .cfg_line_gap           (line_gap_r),
    .cmd                    (cmd),
    .sts                    (sts),
    .out_strobe             (out_valid),
    .out_found              (out_found),
    .out_x_min              (out_x_min),
    .out_y_min              (out_y_min),
    .out_x_max              (out_x_max),
    .out_y_max              (out_y_max),
    .out_advance            (out_advance),
    .out_bitmap_offset      (out_bitmap_offset),
    .out_kern_amount        (out_kern_amount)
  );

endmodule
